// File: sv/jrsu_pkg.sv
// Shared types, character codes and helper functions of the JSON record string unescaper.
`timescale 1ns / 1ps
`default_nettype none
package jrsu_pkg;

   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam int ROLE_LEN    = 4;
   localparam int CONTENT_LEN = 7;

   // Key classification.
   localparam logic [1:0] MATCH_NONE    = 2'd0;
   localparam logic [1:0] MATCH_ROLE    = 2'd1;
   localparam logic [1:0] MATCH_CONTENT = 2'd2;

   // Character codes the parser reacts to.
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_U         = 8'h75;

   // Control bytes produced by the short escapes.
   localparam logic [7:0] CTL_BS = 8'h08;
   localparam logic [7:0] CTL_HT = 8'h09;
   localparam logic [7:0] CTL_LF = 8'h0A;
   localparam logic [7:0] CTL_FF = 8'h0C;
   localparam logic [7:0] CTL_CR = 8'h0D;

   // UTF-8 lead and continuation marks.
   localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0]  UTF8_CONT  = 8'h80;
   localparam logic [5:0]  UTF8_MASK  = 6'h3F;
   localparam logic [15:0] UTF8_TWO   = 16'h0080;
   localparam logic [15:0] UTF8_THREE = 16'h0800;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_field;
      logic       byte_valid;
      logic       line_done;
      logic       line_ok;
      logic       run_last;
   } rsp_item_type;

   // Results caused by one accepted input beat.
   typedef struct packed {
      logic [1:0]                         count;
      rsp_item_type [MAX_RESULTS-1:0]     item;
   } push_type;

   function automatic logic [7:0] role_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = 8'h72;
         2'd1:    ch = 8'h6F;
         2'd2:    ch = 8'h6C;
         default: ch = 8'h65;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] content_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0:    ch = 8'h63;
         3'd1:    ch = 8'h6F;
         3'd2:    ch = 8'h6E;
         3'd3:    ch = 8'h74;
         3'd4:    ch = 8'h65;
         3'd5:    ch = 8'h6E;
         3'd6:    ch = 8'h74;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Bit 4 flags a hex digit; bits 3:0 carry its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] d;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = {1'b1, 4'(c - 8'h37)};
      end else begin
         d = 5'd0;
      end
      return d;
   endfunction

endpackage
`default_nettype wire

// File: sv/jrsu_parser.sv
// Line parser: state registers and the per-byte decode that yields up to three results.
`timescale 1ns / 1ps
`default_nettype none
module jrsu_parser
   import jrsu_pkg::*;
#(
   parameter int KEY_LIMIT = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] in_byte,
   input  wire logic       end_of_line,
   output push_type        push
);

   localparam int KEY_LEN_W = $clog2(KEY_LIMIT);

   typedef enum logic [7:0] {
      PH_LEAD    = 8'b0000_0001,
      PH_PREKEY  = 8'b0000_0010,
      PH_KEY     = 8'b0000_0100,
      PH_POSTKEY = 8'b0000_1000,
      PH_VALUE   = 8'b0001_0000,
      PH_ESC     = 8'b0010_0000,
      PH_HEX     = 8'b0100_0000,
      PH_DONE    = 8'b1000_0000
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic                 pair_ff, pair_in;
   logic [KEY_LEN_W-1:0] key_len_ff, key_len_in;
   logic                 role_ok_ff, role_ok_in;
   logic                 content_ok_ff, content_ok_in;
   logic [1:0]           match_ff, match_in;
   logic [1:0]           hex_cnt_ff, hex_cnt_in;
   logic [15:0]          hex_val_ff, hex_val_in;
   logic                 hex_stop_ff, hex_stop_in;
   logic                 role_seen_ff, role_seen_in;
   logic                 content_seen_ff, content_seen_in;
   logic                 failed_ff, failed_in;

   logic [7:0]  b0, b1, b2;
   logic [1:0]  n_bytes;
   logic [4:0]  digit;
   logic [15:0] code;
   logic        emit_en;
   logic        terminator;

   assign digit      = hex_digit(in_byte);
   assign emit_en    = (match_ff != MATCH_NONE);
   assign terminator = end_of_line || (in_byte == CH_NUL);
   assign code       = (!hex_stop_ff && digit[4]) ? {hex_val_ff[11:0], digit[3:0]} : hex_val_ff;

   always_comb begin
      phase_in        = phase_ff;
      pair_in         = pair_ff;
      key_len_in      = key_len_ff;
      role_ok_in      = role_ok_ff;
      content_ok_in   = content_ok_ff;
      match_in        = match_ff;
      hex_cnt_in      = hex_cnt_ff;
      hex_val_in      = hex_val_ff;
      hex_stop_in     = hex_stop_ff;
      role_seen_in    = role_seen_ff;
      content_seen_in = content_seen_ff;
      failed_in       = failed_ff;
      b0              = in_byte;
      b1              = 8'h00;
      b2              = 8'h00;
      n_bytes         = 2'd0;
      push            = '0;

      if (terminator) begin
         push.count            = 2'd1;
         push.item[0].line_done = 1'b1;
         push.item[0].line_ok   = !failed_ff && (phase_ff == PH_DONE) &&
                                  role_seen_ff && content_seen_ff;
         push.item[0].run_last  = 1'b1;
         phase_in        = PH_LEAD;
         pair_in         = 1'b0;
         key_len_in      = '0;
         match_in        = MATCH_NONE;
         hex_cnt_in      = 2'd0;
         hex_val_in      = 16'h0000;
         hex_stop_in     = 1'b0;
         role_seen_in    = 1'b0;
         content_seen_in = 1'b0;
         failed_in       = 1'b0;
      end else if (!failed_ff) begin
         unique case (phase_ff)
            PH_LEAD: begin
               if (in_byte == CH_LBRACE) begin
                  phase_in = PH_PREKEY;
               end else if (in_byte != CH_SPACE && in_byte != CH_TAB) begin
                  failed_in = 1'b1;
               end
            end
            PH_PREKEY: begin
               if (in_byte == CH_QUOTE) begin
                  phase_in      = PH_KEY;
                  key_len_in    = '0;
                  role_ok_in    = 1'b1;
                  content_ok_in = 1'b1;
               end else if (in_byte != CH_SPACE && in_byte != CH_COMMA) begin
                  failed_in = 1'b1;
               end
            end
            PH_KEY: begin
               if (in_byte == CH_QUOTE) begin
                  if (role_ok_ff && key_len_ff == KEY_LEN_W'(ROLE_LEN)) begin
                     match_in = MATCH_ROLE;
                  end else if (content_ok_ff && key_len_ff == KEY_LEN_W'(CONTENT_LEN)) begin
                     match_in = MATCH_CONTENT;
                  end else begin
                     match_in = MATCH_NONE;
                  end
                  phase_in = PH_POSTKEY;
               end else if (key_len_ff == KEY_LEN_W'(KEY_LIMIT - 1)) begin
                  failed_in = 1'b1;
               end else begin
                  // Track the two known keys as the bytes arrive; a longer key
                  // is ruled out by its length at the closing quote.
                  if (key_len_ff < KEY_LEN_W'(ROLE_LEN) &&
                      in_byte != role_char(key_len_ff[1:0])) begin
                     role_ok_in = 1'b0;
                  end
                  if (key_len_ff < KEY_LEN_W'(CONTENT_LEN) &&
                      in_byte != content_char(key_len_ff[2:0])) begin
                     content_ok_in = 1'b0;
                  end
                  key_len_in = key_len_ff + KEY_LEN_W'(1);
               end
            end
            PH_POSTKEY: begin
               if (in_byte == CH_QUOTE) begin
                  phase_in = PH_VALUE;
               end else if (in_byte != CH_SPACE && in_byte != CH_COLON) begin
                  failed_in = 1'b1;
               end
            end
            PH_VALUE: begin
               if (in_byte == CH_QUOTE) begin
                  if (match_ff == MATCH_ROLE) begin
                     role_seen_in = 1'b1;
                  end
                  if (match_ff == MATCH_CONTENT) begin
                     content_seen_in = 1'b1;
                  end
                  pair_in  = 1'b1;
                  phase_in = pair_ff ? PH_DONE : PH_PREKEY;
               end else if (in_byte == CH_BACKSLASH) begin
                  phase_in = PH_ESC;
               end else begin
                  n_bytes = 2'd1;
               end
            end
            PH_ESC: begin
               phase_in = PH_VALUE;
               n_bytes  = 2'd1;
               case (in_byte)
                  CH_N: b0 = CTL_LF;
                  CH_R: b0 = CTL_CR;
                  CH_T: b0 = CTL_HT;
                  CH_B: b0 = CTL_BS;
                  CH_F: b0 = CTL_FF;
                  CH_U: begin
                     phase_in    = PH_HEX;
                     n_bytes     = 2'd0;
                     hex_cnt_in  = 2'd0;
                     hex_val_in  = 16'h0000;
                     hex_stop_in = 1'b0;
                  end
                  default: b0 = in_byte;
               endcase
            end
            PH_HEX: begin
               hex_val_in  = code;
               hex_stop_in = hex_stop_ff || !digit[4];
               hex_cnt_in  = hex_cnt_ff + 2'd1;
               if (hex_cnt_ff == 2'd3) begin
                  if (code < UTF8_TWO) begin
                     n_bytes = 2'd1;
                     b0      = code[7:0];
                  end else if (code < UTF8_THREE) begin
                     n_bytes = 2'd2;
                     b0      = UTF8_LEAD2 | {3'b000, code[10:6]};
                     b1      = UTF8_CONT | {2'b00, code[5:0] & UTF8_MASK};
                  end else begin
                     n_bytes = 2'd3;
                     b0      = UTF8_LEAD3 | {4'h0, code[15:12]};
                     b1      = UTF8_CONT | {2'b00, code[11:6] & UTF8_MASK};
                     b2      = UTF8_CONT | {2'b00, code[5:0] & UTF8_MASK};
                  end
                  hex_cnt_in  = 2'd0;
                  hex_val_in  = 16'h0000;
                  hex_stop_in = 1'b0;
                  phase_in    = PH_VALUE;
               end
            end
            PH_DONE: begin
               // Trailing bytes are ignored until the terminator.
            end
            default: begin
               failed_in = 1'b1;
            end
         endcase

         if (emit_en) begin
            push.count = n_bytes;
            for (int i = 0; i < MAX_RESULTS; i++) begin
               push.item[i].out_field  = (match_ff == MATCH_CONTENT);
               push.item[i].byte_valid = 1'b1;
               push.item[i].run_last   = (2'(i + 1) == n_bytes);
            end
            push.item[0].out_byte = b0;
            push.item[1].out_byte = b1;
            push.item[2].out_byte = b2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_LEAD;
         pair_ff         <= 1'b0;
         key_len_ff      <= '0;
         role_ok_ff      <= 1'b0;
         content_ok_ff   <= 1'b0;
         match_ff        <= MATCH_NONE;
         hex_cnt_ff      <= 2'd0;
         hex_val_ff      <= 16'h0000;
         hex_stop_ff     <= 1'b0;
         role_seen_ff    <= 1'b0;
         content_seen_ff <= 1'b0;
         failed_ff       <= 1'b0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         pair_ff         <= pair_in;
         key_len_ff      <= key_len_in;
         role_ok_ff      <= role_ok_in;
         content_ok_ff   <= content_ok_in;
         match_ff        <= match_in;
         hex_cnt_ff      <= hex_cnt_in;
         hex_val_ff      <= hex_val_in;
         hex_stop_ff     <= hex_stop_in;
         role_seen_ff    <= role_seen_in;
         content_seen_ff <= content_seen_in;
         failed_ff       <= failed_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/jrsu_rsp_queue.sv
// Four-entry result queue: takes up to three results per beat, drains one per cycle while rsp_ready is high.
`timescale 1ns / 1ps
`default_nettype none
module jrsu_rsp_queue
   import jrsu_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_en,
   input  wire push_type push,
   output logic          room,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_item_type  head
);

   rsp_item_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [1:0]             n_push;
   logic                   pop;

   assign n_push    = push_en ? push.count : 2'd0;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   // A full burst must fit whatever the consumer does this cycle.
   assign room      = (count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH - MAX_RESULTS));

   assign wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(n_push);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
   assign count_in  = count_ff + QUEUE_CNT_W'(n_push) - QUEUE_CNT_W'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (2'(i) < n_push) begin
            slot_ff[wr_ptr_ff + QUEUE_PTR_W'(i)] <= push.item[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/json_record_string_unescaper_unit.sv
// Top level of the JSON record string unescaper: request port, parser and result queue.
`timescale 1ns / 1ps
`default_nettype none
// This block parses one line of the form {"key":"value","key":"value"}, one byte per
// request beat, and returns the unescaped value bytes of the keys role and content as
// response beats, followed by one verdict beat per line. A request beat whose
// end_of_line bit is set, or whose byte is zero, ends the line and yields the verdict;
// every other byte yields zero to three value beats, three only for a \uXXXX escape at
// or above U+0800. Each request beat is decoded in the cycle it is accepted and its
// results land in a four-entry response queue, so the block takes one byte per clock
// as long as the consumer drains one beat per clock and no byte yields more than one
// beat. The request side is ready while the queue holds at most one beat, which leaves
// room for a full three-beat burst; with the consumer draining every cycle, a two-beat
// or three-beat burst pauses the request side while the queue drains. The results of
// an accepted byte are registered in the queue, so no response beat appears in the
// same cycle as the byte that causes it. On a verdict of zero the consumer throws away
// the value bytes it received for that line. The parameter KEY_LIMIT sets the key length at which a key fails the line.
module json_record_string_unescaper_unit
   import jrsu_pkg::*;
#(
   parameter int KEY_LIMIT = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_end_of_line,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_field,
   output logic            rsp_byte_valid,
   output logic            rsp_line_done,
   output logic            rsp_line_ok,
   output logic            rsp_run_last
);

   logic         req_accept;
   logic         room;
   push_type     push;
   rsp_item_type head;

   assign req_ready  = room;
   assign req_accept = req_valid && req_ready;

   // Parser state advances only on an accepted beat; its results go straight to the queue.
   jrsu_parser #(
      .KEY_LIMIT(KEY_LIMIT)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .in_byte     (req_in_byte),
      .end_of_line (req_end_of_line),
      .push        (push)
   );

   jrsu_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_en   (req_accept),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_out_byte   = head.out_byte;
   assign rsp_out_field  = head.out_field;
   assign rsp_byte_valid = head.byte_valid;
   assign rsp_line_done  = head.line_done;
   assign rsp_line_ok    = head.line_ok;
   assign rsp_run_last   = head.run_last;

endmodule
`default_nettype wire

// File: sv/jrsu_checker.sv
// Port-level checker for the JSON record string unescaper and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module jrsu_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_out_field,
   input wire logic       rsp_byte_valid,
   input wire logic       rsp_line_done,
   input wire logic       rsp_line_ok,
   input wire logic       rsp_run_last
);

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_out_field) && $stable(rsp_byte_valid) && $stable(rsp_line_done) &&
      $stable(rsp_line_ok) && $stable(rsp_run_last))
      else $error("response beat changed while stalled");

   // Each beat is either a value byte or a verdict, never both nor neither.
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_valid != rsp_line_done))
      else $error("response beat is not exactly one of value byte or verdict");

   // The verdict always closes the run of its request beat.
   a_verdict_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_done |-> rsp_run_last)
      else $error("verdict beat without run_last");

   // A positive verdict only rides on a verdict beat.
   a_ok_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_ok |-> rsp_line_done)
      else $error("line_ok set on a value byte beat");

endmodule

bind json_record_string_unescaper_unit jrsu_checker u_jrsu_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_out_field  (rsp_out_field),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_line_done  (rsp_line_done),
   .rsp_line_ok    (rsp_line_ok),
   .rsp_run_last   (rsp_run_last)
);
`default_nettype wire

// File: verif/json_record_string_unescaper_unit_tb.sv
// Self-checking testbench of the JSON record string unescaper with predictor and checker.
`timescale 1ns / 1ps
module json_record_string_unescaper_unit_tb;
   import jrsu_pkg::*;

   // Key length at which the block fails a line; the instance uses the same value.
   localparam int KEY_LIMIT       = 16;
   // Length of the one long consumer stall that fills the response queue.
   localparam int RSP_HOLD_CYCLES = 60;
   // Least number of request beats of the whole run, and the tail in which nobody idles any more.
   localparam int TOTAL_BEATS     = 270;
   localparam int CALM_TAIL_BEATS = 30;

   // Parser phases of the predictor.
   typedef enum logic [3:0] {
      SCAN_LEAD, SCAN_PREKEY, SCAN_KEY, SCAN_POSTKEY,
      SCAN_VALUE, SCAN_ESCAPE, SCAN_HEX, SCAN_DONE
   } scan_phase_type;

   // One request beat waiting to be offered, with the pacing hints that ride along.
   typedef struct {
      logic [7:0] data;
      logic       eol;
      bit         calm;   // no idling on either side from this beat on
      bit         drain;  // do not offer until every expected beat has come back
      bit         hold;   // acceptance starts the long consumer stall
   } line_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_line = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_field;
   logic       rsp_byte_valid;
   logic       rsp_line_done;
   logic       rsp_line_ok;
   logic       rsp_run_last;

   json_record_string_unescaper_unit #(
      .KEY_LIMIT(KEY_LIMIT)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_end_of_line(req_end_of_line),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_field  (rsp_out_field),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_line_done  (rsp_line_done),
      .rsp_line_ok    (rsp_line_ok),
      .rsp_run_last   (rsp_run_last)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Predictor state: a private copy of the parser, advanced once per
   // accepted request beat.
   // ------------------------------------------------------------------
   scan_phase_type scan_phase  = SCAN_LEAD;
   int unsigned  pairs_taken = 0;
   int unsigned  key_len     = 0;
   logic [1:0]   key_kind    = MATCH_NONE;
   logic [7:0]   key_text [KEY_LIMIT-1];
   int unsigned  hex_seen    = 0;
   logic [15:0]  hex_acc     = '0;
   bit           hex_halted  = 1'b0;
   bit           saw_role    = 1'b0;
   bit           saw_content = 1'b0;
   bit           line_bad    = 1'b0;

   rsp_item_type  decoded_q[$];       // response beats still owed by the block
   rsp_item_type  value_burst_q[$];   // beats caused by the byte being decoded
   line_beat_type line_bytes_q[$];    // request beats not yet offered
   line_beat_type offer_beat;
   logic [7:0]    line_text[$];       // scratch buffer of the random line builder

   int  fault_count = 0;
   bit  req_fire = 1'b0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   bit  beat_marks_hold = 1'b0;
   bit  hold_armed = 1'b0;
   bit  rsp_hold = 1'b0;
   bit  quiet_tail = 1'b0;
   bit  next_calm = 1'b0;
   bit  next_drain = 1'b0;
   bit  next_hold = 1'b0;

   // A verdict wipes everything that belongs to the line; the key bytes stay
   // but are only ever read below the new key length.
   task automatic clear_line_state();
      scan_phase  = SCAN_LEAD;
      pairs_taken = 0;
      key_len     = 0;
      key_kind    = MATCH_NONE;
      hex_seen    = 0;
      hex_acc     = '0;
      hex_halted  = 1'b0;
      saw_role    = 1'b0;
      saw_content = 1'b0;
      line_bad    = 1'b0;
   endtask

   function automatic bit key_equals(input string word);
      bit same;
      same = (key_len == word.len());
      for (int i = 0; i < word.len() && same; i++) begin
         if (key_text[i] != word[i]) same = 1'b0;
      end
      return same;
   endfunction

   function automatic int hex_nibble(input logic [7:0] c);
      int v;
      if (c >= "0" && c <= "9") v = int'(c) - int'("0");
      else if (c >= "a" && c <= "f") v = int'(c) - int'("a") + 10;
      else if (c >= "A" && c <= "F") v = int'(c) - int'("A") + 10;
      else v = -1;
      return v;
   endfunction

   // Value bytes only leave the block when the current key is role or content.
   task automatic emit_value(input logic [7:0] d);
      rsp_item_type r;
      if (key_kind != MATCH_NONE) begin
         r = '0;
         r.out_byte   = d;
         r.out_field  = (key_kind == MATCH_CONTENT);
         r.byte_valid = 1'b1;
         value_burst_q.push_back(r);
      end
   endtask

   // Advances the parser by one request beat and queues the beats it causes.
   task automatic decode_input_byte(input logic [7:0] c, input logic eol);
      rsp_item_type verdict;
      int           nib;
      logic [15:0]  code;
      value_burst_q = {};
      if (eol || c == CH_NUL) begin
         verdict           = '0;
         verdict.line_done = 1'b1;
         verdict.line_ok   = !line_bad && scan_phase == SCAN_DONE && saw_role && saw_content;
         verdict.run_last  = 1'b1;
         decoded_q.push_back(verdict);
         clear_line_state();
      end else if (!line_bad) begin
         case (scan_phase)
            SCAN_LEAD: begin
               if (c == CH_LBRACE) scan_phase = SCAN_PREKEY;
               else if (c != CH_SPACE && c != CH_TAB) line_bad = 1'b1;
            end
            SCAN_PREKEY: begin
               if (c == CH_QUOTE) begin
                  scan_phase = SCAN_KEY;
                  key_len    = 0;
               end else if (c != CH_SPACE && c != CH_COMMA) begin
                  line_bad = 1'b1;
               end
            end
            SCAN_KEY: begin
               if (c == CH_QUOTE) begin
                  if (key_equals("role")) key_kind = MATCH_ROLE;
                  else if (key_equals("content")) key_kind = MATCH_CONTENT;
                  else key_kind = MATCH_NONE;
                  scan_phase = SCAN_POSTKEY;
               end else if (key_len >= KEY_LIMIT - 1) begin
                  // The key byte that reaches the limit fails the line.
                  line_bad = 1'b1;
               end else begin
                  key_text[key_len] = c;
                  key_len++;
               end
            end
            SCAN_POSTKEY: begin
               if (c == CH_QUOTE) scan_phase = SCAN_VALUE;
               else if (c != CH_SPACE && c != CH_COLON) line_bad = 1'b1;
            end
            SCAN_VALUE: begin
               if (c == CH_QUOTE) begin
                  if (key_kind == MATCH_ROLE) saw_role = 1'b1;
                  if (key_kind == MATCH_CONTENT) saw_content = 1'b1;
                  pairs_taken++;
                  scan_phase = (pairs_taken >= 2) ? SCAN_DONE : SCAN_PREKEY;
               end else if (c == CH_BACKSLASH) begin
                  scan_phase = SCAN_ESCAPE;
               end else begin
                  emit_value(c);
               end
            end
            SCAN_ESCAPE: begin
               scan_phase = SCAN_VALUE;
               case (c)
                  CH_N:    emit_value(CTL_LF);
                  CH_R:    emit_value(CTL_CR);
                  CH_T:    emit_value(CTL_HT);
                  CH_B:    emit_value(CTL_BS);
                  CH_F:    emit_value(CTL_FF);
                  CH_U: begin
                     scan_phase = SCAN_HEX;
                     hex_seen   = 0;
                     hex_acc    = '0;
                     hex_halted = 1'b0;
                  end
                  // Any other escaped byte stands for itself.
                  default: emit_value(c);
               endcase
            end
            SCAN_HEX: begin
               // Four bytes are always swallowed; the first non-digit freezes the code.
               nib = hex_nibble(c);
               if (!hex_halted && nib >= 0) hex_acc = {hex_acc[11:0], 4'(nib)};
               else hex_halted = 1'b1;
               hex_seen++;
               if (hex_seen >= 4) begin
                  code = hex_acc;
                  if (code < UTF8_TWO) begin
                     emit_value(code[7:0]);
                  end else if (code < UTF8_THREE) begin
                     emit_value(UTF8_LEAD2 | 8'(code >> 6));
                     emit_value(UTF8_CONT | {2'b00, code[5:0] & UTF8_MASK});
                  end else begin
                     emit_value(UTF8_LEAD3 | 8'(code >> 12));
                     emit_value(UTF8_CONT | {2'b00, code[11:6]});
                     emit_value(UTF8_CONT | {2'b00, code[5:0]});
                  end
                  hex_seen   = 0;
                  hex_acc    = '0;
                  hex_halted = 1'b0;
                  scan_phase = SCAN_VALUE;
               end
            end
            default: ;
         endcase
         if (value_burst_q.size() > 0) begin
            value_burst_q[value_burst_q.size()-1].run_last = 1'b1;
         end
         foreach (value_burst_q[i]) decoded_q.push_back(value_burst_q[i]);
      end
   endtask

   task automatic report_fault(input string msg);
      if (fault_count < 10) $display("%s", msg);
      fault_count++;
   endtask

   // Compares one accepted response beat with the oldest expectation.
   task automatic check_result();
      rsp_item_type want;
      if (decoded_q.size() == 0) begin
         report_fault($sformatf(
            "unexpected beat: byte=%02h field=%0b valid=%0b done=%0b ok=%0b last=%0b",
            rsp_out_byte, rsp_out_field, rsp_byte_valid, rsp_line_done, rsp_line_ok,
            rsp_run_last));
      end else begin
         want = decoded_q.pop_front();
         if (rsp_out_byte !== want.out_byte || rsp_out_field !== want.out_field ||
             rsp_byte_valid !== want.byte_valid || rsp_line_done !== want.line_done ||
             rsp_line_ok !== want.line_ok || rsp_run_last !== want.run_last) begin
            report_fault({$sformatf(
               "mismatch: expected byte=%02h field=%0b valid=%0b done=%0b ok=%0b last=%0b",
               want.out_byte, want.out_field, want.byte_valid, want.line_done,
               want.line_ok, want.run_last),
               $sformatf(", got byte=%02h field=%0b valid=%0b done=%0b ok=%0b last=%0b",
               rsp_out_byte, rsp_out_field, rsp_byte_valid, rsp_line_done, rsp_line_ok,
               rsp_run_last)});
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sampling at the rising edge. The predictor runs on every accepted
   // request beat before the response side is checked; a response never
   // comes in the same cycle as the byte that causes it anyway.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && req_ready;
      if (reset) begin
         clear_line_state();
      end else begin
         if (req_valid && req_ready) begin
            decode_input_byte(req_in_byte, req_end_of_line);
            if (beat_marks_hold) hold_armed <= 1'b1;
         end
         if (rsp_valid && rsp_ready) check_result();
      end
   end

   // ------------------------------------------------------------------
   // Request driver. It changes inputs at the falling edge only, keeps a
   // beat steady until it was taken, and inserts random idle bursts unless
   // the beat belongs to the calm tail of the run.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // Offered beat not taken yet: hold it.
      end else if (req_gap > 0) begin
         req_gap   <= req_gap - 1;
         req_valid <= 1'b0;
      end else if (line_bytes_q.size() == 0) begin
         req_valid <= 1'b0;
      end else if (line_bytes_q[0].drain && decoded_q.size() != 0) begin
         // The sender sits out until the block has returned everything.
         req_valid <= 1'b0;
      end else if (!line_bytes_q[0].calm && $urandom_range(0, 9) == 0) begin
         req_gap   <= $urandom_range(0, 5);
         req_valid <= 1'b0;
      end else begin
         offer_beat = line_bytes_q.pop_front();
         req_in_byte     <= offer_beat.data;
         req_end_of_line <= offer_beat.eol;
         req_valid       <= 1'b1;
         beat_marks_hold <= offer_beat.hold;
         if (offer_beat.calm) quiet_tail <= 1'b1;
      end
   end

   // Response consumer: random stall bursts, the long hold, and none at the end.
   always @(negedge clock) begin
      if (reset || rsp_hold) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap   <= rsp_gap - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         rsp_gap   <= $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // The long consumer stall is timed here, in cycles. It starts once the
   // marked byte has been accepted, while the sender keeps offering value
   // bytes, so the response queue fills and the request side backs off.
   initial begin
      while (!hold_armed) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (RSP_HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Stimulus builders.
   // ------------------------------------------------------------------
   task automatic queue_beat(input logic [7:0] data, input logic eol);
      line_beat_type b;
      b.data  = data;
      b.eol   = eol;
      b.calm  = next_calm;
      b.drain = next_drain;
      b.hold  = next_hold;
      next_drain = 1'b0;
      next_hold  = 1'b0;
      line_bytes_q.push_back(b);
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_beat(s[i], 1'b0);
   endtask

   // The byte that travels with a terminator beat is ignored, so it is random.
   task automatic queue_eol();
      queue_beat(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // Appends a word to the line being built.
   task automatic push_word(input string s);
      for (int i = 0; i < s.len(); i++) line_text.push_back(s[i]);
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] v;
      do v = 8'($urandom_range(1, 255)); while (v == CH_QUOTE || v == CH_BACKSLASH);
      return v;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] ch;
      if (v < 10) ch = 8'("0") + 8'(v);
      else if ($urandom_range(0, 1) != 0) ch = 8'("A") + 8'(v) - 8'd10;
      else ch = 8'("a") + 8'(v) - 8'd10;
      return ch;
   endfunction

   // Appends one piece of a value: a plain byte, a short escape, a \u escape
   // in one of the three UTF-8 length bands, or a \u escape with stray bytes.
   task automatic add_value_piece();
      int unsigned kind;
      int unsigned stop;
      logic [15:0] cp;
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
         line_text.push_back(plain_byte());
      end else if (kind == 5) begin
         line_text.push_back(CH_BACKSLASH);
         case ($urandom_range(0, 8))
            0: line_text.push_back(CH_N);
            1: line_text.push_back(CH_R);
            2: line_text.push_back(CH_T);
            3: line_text.push_back(CH_B);
            4: line_text.push_back(CH_F);
            5: line_text.push_back(CH_QUOTE);
            6: line_text.push_back(CH_BACKSLASH);
            7: line_text.push_back("/");
            default: line_text.push_back(8'($urandom_range(1, 255)));
         endcase
      end else if (kind <= 8) begin
         case ($urandom_range(0, 2))
            0: cp = 16'($urandom_range(0, 16'h007F));
            1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
            default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
         endcase
         line_text.push_back(CH_BACKSLASH);
         line_text.push_back(CH_U);
         for (int i = 3; i >= 0; i--) line_text.push_back(hex_char(cp[4*i +: 4]));
      end else begin
         stop = $urandom_range(0, 3);
         line_text.push_back(CH_BACKSLASH);
         line_text.push_back(CH_U);
         for (int i = 0; i < 4; i++) begin
            if (i < stop) line_text.push_back(hex_char(4'($urandom_range(0, 15))));
            else line_text.push_back(8'($urandom_range(1, 255)));
         end
      end
   endtask

   // Mostly well-formed lines with random keys, separators and values; a few
   // are cut short, get a wrong byte, carry trailing bytes, or are plain noise.
   task automatic queue_random_line();
      int unsigned pick;
      int unsigned cut;
      line_text = {};
      if ($urandom_range(0, 11) == 0) begin
         repeat ($urandom_range(1, 6)) line_text.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 2))
            line_text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
         line_text.push_back(CH_LBRACE);
         for (int p = 0; p < 2; p++) begin
            repeat ($urandom_range(0, 2))
               line_text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_COMMA);
            line_text.push_back(CH_QUOTE);
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               push_word("role");
            end else if (pick < 8) begin
               push_word("content");
            end else begin
               // Unknown keys, including lengths around the limit.
               repeat (pick == 8 ? $urandom_range(0, 5)
                                 : $urandom_range(KEY_LIMIT - 2, KEY_LIMIT + 1))
                  line_text.push_back(plain_byte());
            end
            line_text.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 2))
               line_text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_COLON);
            line_text.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 5)) add_value_piece();
            line_text.push_back(CH_QUOTE);
         end
         case ($urandom_range(0, 9))
            0: begin
               cut = $urandom_range(0, line_text.size() - 1);
               while (line_text.size() > cut) void'(line_text.pop_back());
            end
            1: line_text[$urandom_range(0, line_text.size() - 1)] = 8'($urandom_range(1, 255));
            2: repeat ($urandom_range(1, 3)) line_text.push_back(8'($urandom_range(1, 255)));
            default: ;
         endcase
      end
      foreach (line_text[i]) queue_beat(line_text[i], 1'b0);
      if ($urandom_range(0, 5) == 0) queue_beat(CH_NUL, 1'b0);
      else queue_eol();
   endtask

   // ------------------------------------------------------------------
   // Main sequence: fill the stimulus queue, release reset, wait for the
   // traffic to finish and give the verdict.
   // ------------------------------------------------------------------
   initial begin
      int drain_wait;

      // Both keys, every UTF-8 length with its band edges, an unknown escape,
      // and trailing bytes after the second pair.
      queue_beat(CH_TAB, 1'b0);
      queue_text(" {\"role\":\"\\u007F\\u0080\\q\",\"content\":\"\\uFFFF\\u0800\\u07ff\\n\"}");
      queue_eol();
      // Short escapes \t \b \f \" \\ \/, the top byte value, a \u that swallows
      // quotes and yields a zero byte, then a zero byte ending the line inside a \u.
      queue_text("{\"content\":\"\\t\\b\\f\\\"\\\\\\/");
      queue_beat(8'hFF, 1'b0);
      queue_text("\\u\"1x\"\",\"role\":\"\\u0F");
      queue_beat(CH_NUL, 1'b0);
      // A byte that does not belong before the brace; the rest is ignored.
      queue_text("x{");
      queue_eol();
      // A key that reaches the length limit.
      queue_text("{\"");
      repeat (KEY_LIMIT) queue_beat("k", 1'b0);
      queue_text("\":\"a\"");
      queue_eol();
      // The same key twice: both values come out, the verdict is still zero.
      queue_text("{\"role\":\"a\" \"role\":\"b\"}zz");
      queue_beat(CH_NUL, 1'b0);

      // A line with a dense content value; its first value byte starts the
      // long consumer stall, and the line after it waits for a full drain.
      queue_text("{\"content\":\"");
      next_hold = 1'b1;
      queue_text("\\uABCD\\u0800\\uffff\\u1234\\u7FFF\\u0900xyz\",\"role\":\"r\"}");
      queue_eol();
      next_drain = 1'b1;

      while (line_bytes_q.size() < TOTAL_BEATS) begin
         if (line_bytes_q.size() >= TOTAL_BEATS - CALM_TAIL_BEATS) begin
            next_calm = 1'b1;
         end
         queue_random_line();
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (line_bytes_q.size() != 0 || req_valid) @(posedge clock);
      drain_wait = 0;
      while (decoded_q.size() != 0 && drain_wait < 5000) begin
         @(posedge clock);
         drain_wait++;
      end
      // A further wait catches any stray beat after the last expected one.
      repeat (20) @(posedge clock);
      if (decoded_q.size() != 0) begin
         report_fault($sformatf("%0d expected beats never arrived", decoded_q.size()));
      end
      if (fault_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

endmodule

// File: json_record_string_unescaper_unit.f
sv/jrsu_pkg.sv
sv/jrsu_parser.sv
sv/jrsu_rsp_queue.sv
sv/json_record_string_unescaper_unit.sv
sv/jrsu_checker.sv
verif/json_record_string_unescaper_unit_tb.sv
